[rtl/core/fsrs_pkg.sv]
// ============================================================================
// fsrs_pkg
// Types and constants shared by the floppy sector read sequencer.
// ============================================================================
package fsrs_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SEEK  = 2'd1,
    PH_RECAL = 2'd2,
    PH_READ  = 2'd3
  } phase_t;

  localparam logic [2:0] ACT_DOR     = 3'd0;
  localparam logic [2:0] ACT_FIFO    = 3'd1;
  localparam logic [2:0] ACT_WAIT    = 3'd2;
  localparam logic [2:0] ACT_DISCARD = 3'd3;
  localparam logic [2:0] ACT_DMA     = 3'd4;
  localparam logic [2:0] ACT_DONE    = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BAD   = 3'd1;
  localparam logic [2:0] ST_POS   = 3'd2;
  localparam logic [2:0] ST_TMO   = 3'd3;
  localparam logic [2:0] ST_ABN   = 3'd4;
  localparam logic [2:0] ST_CRC   = 3'd5;

  localparam logic [1:0] MODE_REQ   = 2'd0;
  localparam logic [1:0] MODE_SENSE = 2'd1;
  localparam logic [1:0] MODE_RES   = 2'd2;

  localparam logic [2:0] REG_SPINUP = 3'd0;
  localparam logic [2:0] REG_SEEK   = 3'd1;
  localparam logic [2:0] REG_RECAL  = 3'd2;
  localparam logic [2:0] REG_GAP    = 3'd3;
  localparam logic [2:0] REG_STEP   = 3'd4;
  localparam logic [2:0] REG_LOAD   = 3'd5;

  // One command from front to back: a chain of scripts with its operands.
  typedef struct packed {
    logic       do_retry;
    logic       do_motor;
    logic       spin;
    logic       do_seek;
    logic       do_read;
    logic       do_done;
    logic [2:0] status;
    logic       drive;
    logic [7:0] track;
    logic       head;
    logic [5:0] sector;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [9:0] wait_ms;
    logic [2:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] drive;
    logic [15:0] lba;
    logic [7:0] st0;
    logic [7:0] st1;
    logic [7:0] st2;
    logic       timed_out;
  } req_t;

endpackage

[rtl/core/fsrs_if.sv]
// ============================================================================
// fsrs_if
// Valid/ready channel carrying one payload beat.
// ============================================================================
interface fsrs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/fsrs_front.sv]
// ============================================================================
// fsrs_front
// Accepts requests and replies, keeps sequencer state, and issues commands.
// ============================================================================
module fsrs_front #(
  parameter int SPT = 18,
  parameter int CYL = 80
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fsrs_pkg::req_t  req,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output fsrs_pkg::cmd_t  cmd
);
  import fsrs_pkg::*;

  localparam int TOTAL = CYL * 2 * SPT;
  // Rounded-up reciprocal of the sector count; exact for any 16 bit LBA.
  localparam int RECIP_K = 22;
  localparam logic [22:0] RECIP =
    23'(((64'd1 << RECIP_K) + 64'(SPT - 1)) / 64'(SPT));

  phase_t     phase;
  logic [7:0] cached_track [2];
  logic [1:0] motor_on_mask;
  logic       rq_drive;
  logic [7:0] rq_track;
  logic       rq_head;
  logic [5:0] rq_sector;
  logic       retry_used;

  // LBA split by reciprocal multiplication: quotient by the sector count,
  // then the remainder by a constant multiply and subtract.
  logic [37:0] prod_w;
  logic [15:0] quo_w, sec_w;
  logic        bad, sense_ok, recal_ok, fire;
  logic [2:0]  rc;
  logic        spin_now;

  assign prod_w = 38'(req.lba) * 38'(RECIP);
  assign quo_w  = prod_w[37:22];
  assign sec_w  = req.lba - quo_w * 16'(SPT);
  assign bad   = (req.drive > 2'd1) || ({16'd0, req.lba} >= 32'(TOTAL));
  assign sense_ok = (req.st0[7:6] == 2'b00) || req.st0[5];
  assign recal_ok = (req.st0[7:6] == 2'b00) || (req.st0[7:6] == 2'b01);
  assign in_ready = !cmd_valid || cmd_ready;
  assign fire     = in_valid && in_ready;
  assign spin_now = !motor_on_mask[req.drive[0]];

  always_comb begin
    if (req.timed_out) rc = ST_TMO;
    else if (req.st0[7]) rc = ST_ABN;
    else if (req.st1[5] || req.st2[5]) rc = ST_CRC;
    else if (req.st1[7]) rc = ST_ABN;
    else rc = ST_OK;
  end

  // Sequencer state and the command register; c and v hold the next command.
  always_ff @(posedge clk) begin
    cmd_t c;
    logic v;
    c = '0;
    c.drive  = rq_drive;
    c.track  = rq_track;
    c.head   = rq_head;
    c.sector = rq_sector;
    v = cmd_valid && !cmd_ready;
    if (rst) begin
      phase           <= PH_IDLE;
      cached_track[0] <= 8'hFF;
      cached_track[1] <= 8'hFF;
      motor_on_mask   <= '0;
      rq_drive        <= 1'b0;
      rq_track        <= '0;
      rq_head         <= 1'b0;
      rq_sector       <= '0;
      retry_used      <= 1'b0;
      cmd_valid       <= 1'b0;
    end else begin
      if (fire) begin
        if (req.mode == MODE_REQ && phase == PH_IDLE) begin
          v = 1'b1;
          if (bad) begin
            c.do_done = 1'b1;
            c.status  = ST_BAD;
          end else begin
            rq_drive   <= req.drive[0];
            rq_track   <= quo_w[8:1];
            rq_head    <= quo_w[0];
            rq_sector  <= sec_w[5:0] + 6'd1;
            retry_used <= 1'b0;
            motor_on_mask[req.drive[0]] <= 1'b1;
            c.drive    = req.drive[0];
            c.track    = quo_w[8:1];
            c.head     = quo_w[0];
            c.sector   = sec_w[5:0] + 6'd1;
            c.do_motor = 1'b1;
            c.spin     = spin_now;
            if (cached_track[req.drive[0]] == quo_w[8:1]) begin
              c.do_read = 1'b1;
              phase <= PH_READ;
            end else begin
              c.do_seek = 1'b1;
              phase <= PH_SEEK;
            end
          end
        end else if (req.mode == MODE_SENSE && phase == PH_SEEK) begin
          v = 1'b1;
          cached_track[rq_drive] <= rq_track;
          if (sense_ok) begin
            c.do_read = 1'b1;
            phase <= PH_READ;
          end else begin
            c.do_done = 1'b1;
            c.status  = ST_POS;
            phase <= PH_IDLE;
          end
        end else if (req.mode == MODE_SENSE && phase == PH_RECAL) begin
          v = 1'b1;
          if (recal_ok) begin
            cached_track[rq_drive] <= 8'hFF;
            c.do_seek = 1'b1;
            phase <= PH_SEEK;
          end else begin
            cached_track[rq_drive] <= 8'h00;
            c.do_done = 1'b1;
            c.status  = ST_POS;
            phase <= PH_IDLE;
          end
        end else if (req.mode == MODE_RES && phase == PH_READ) begin
          v = 1'b1;
          if ((rc == ST_ABN || rc == ST_CRC) && !retry_used) begin
            retry_used    <= 1'b1;
            c.do_retry    = 1'b1;
            c.do_motor    = 1'b1;
            c.spin        = 1'b1;
            motor_on_mask <= rq_drive ? 2'b10 : 2'b01;
            cached_track[0] <= 8'hFF;
            cached_track[1] <= 8'hFF;
            phase <= PH_RECAL;
          end else begin
            c.do_done = 1'b1;
            c.status  = rc;
            phase <= PH_IDLE;
          end
        end
        cmd <= c;
      end
      cmd_valid <= v;
    end
  end
endmodule

[rtl/core/fsrs_back.sv]
// ============================================================================
// fsrs_back
// Plays out one command as action beats, one per cycle barring output stalls.
// ============================================================================
module fsrs_back #(
  parameter int SPT = 18
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [9:0]     spinup_wait_ms,
  input  logic [9:0]     seek_settle_ms,
  input  logic [9:0]     recal_settle_ms,
  input  logic [7:0]     gap_length,
  input  logic [7:0]     step_unload_byte,
  input  logic [7:0]     load_dma_byte,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  fsrs_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output fsrs_pkg::res_t res
);
  import fsrs_pkg::*;

  localparam logic [7:0] SPT_BYTE = 8'(SPT);

  logic       busy;
  cmd_t       cur;
  logic [5:0] step;
  res_t       beat;
  logic       beat_end;
  logic [5:0] step_next;
  logic       advance;
  logic [7:0] hd_byte;

  assign hd_byte = {5'd0, cur.head, 1'b0, cur.drive};

  // Beat table: the retry, motor, seek and read scripts in a row.
  // Steps 0..20 retry, 21..22 motor, 23..27 seek, 28..37 read.
  logic [5:0] pos;
  always_comb begin
    beat = '0;
    beat_end = 1'b0;
    unique case (pos)
      6'd0:  begin beat.action = ACT_DOR;  beat.data_byte = 8'h00; end
      6'd1:  begin beat.action = ACT_WAIT; beat.wait_ms = 10'd5; end
      6'd2:  begin beat.action = ACT_DOR;  beat.data_byte = 8'h0C; end
      6'd3:  begin beat.action = ACT_WAIT; beat.wait_ms = 10'd20; end
      6'd4, 6'd6, 6'd8, 6'd10: begin
        beat.action = ACT_FIFO; beat.data_byte = 8'h08;
      end
      6'd5, 6'd7, 6'd9, 6'd11: beat.action = ACT_DISCARD;
      6'd12: begin beat.action = ACT_FIFO; beat.data_byte = 8'h03; end
      6'd13: begin beat.action = ACT_FIFO; beat.data_byte = step_unload_byte; end
      6'd14: begin beat.action = ACT_FIFO; beat.data_byte = load_dma_byte; end
      6'd15: begin
        beat.action = ACT_DOR;
        beat.data_byte = 8'h0C | (cur.drive ? 8'h21 : 8'h10);
      end
      6'd16: begin beat.action = ACT_WAIT; beat.wait_ms = spinup_wait_ms; end
      6'd17: begin beat.action = ACT_FIFO; beat.data_byte = 8'h07; end
      6'd18: begin beat.action = ACT_FIFO; beat.data_byte = {7'd0, cur.drive}; end
      6'd19: begin beat.action = ACT_WAIT; beat.wait_ms = recal_settle_ms; end
      6'd20: begin
        beat.action = ACT_FIFO; beat.data_byte = 8'h08; beat_end = 1'b1;
      end
      6'd21: begin
        beat.action = ACT_DOR;
        beat.data_byte = 8'h0C | (cur.drive ? 8'h21 : 8'h10);
        beat_end = !cur.spin;
      end
      6'd22: begin
        beat.action = ACT_WAIT; beat.wait_ms = spinup_wait_ms; beat_end = 1'b1;
      end
      6'd23: begin beat.action = ACT_FIFO; beat.data_byte = 8'h0F; end
      6'd24: begin beat.action = ACT_FIFO; beat.data_byte = hd_byte; end
      6'd25: begin beat.action = ACT_FIFO; beat.data_byte = cur.track; end
      6'd26: begin beat.action = ACT_WAIT; beat.wait_ms = seek_settle_ms; end
      6'd27: begin
        beat.action = ACT_FIFO; beat.data_byte = 8'h08; beat_end = 1'b1;
      end
      6'd28: beat.action = ACT_DMA;
      6'd29: begin beat.action = ACT_FIFO; beat.data_byte = 8'h46; end
      6'd30: begin beat.action = ACT_FIFO; beat.data_byte = hd_byte; end
      6'd31: begin beat.action = ACT_FIFO; beat.data_byte = cur.track; end
      6'd32: begin beat.action = ACT_FIFO; beat.data_byte = {7'd0, cur.head}; end
      6'd33: begin beat.action = ACT_FIFO; beat.data_byte = {2'd0, cur.sector}; end
      6'd34: begin beat.action = ACT_FIFO; beat.data_byte = 8'h02; end
      6'd35: begin beat.action = ACT_FIFO; beat.data_byte = SPT_BYTE; end
      6'd36: begin beat.action = ACT_FIFO; beat.data_byte = gap_length; end
      6'd37: begin
        beat.action = ACT_FIFO; beat.data_byte = 8'hFF; beat_end = 1'b1;
      end
      default: beat = '0;
    endcase
  end

  assign pos = step;

  // Pick the first pending script from the flags left in cur.
  function automatic logic [5:0] start_of(cmd_t c);
    if (c.do_retry) return 6'd0;
    else if (c.do_motor) return 6'd21;
    else if (c.do_seek) return 6'd23;
    else if (c.do_read) return 6'd28;
    else return 6'd0;
  endfunction

  cmd_t cur_next;
  logic last_script;

  always_comb begin
    cur_next = cur;
    last_script = 1'b0;
    step_next = step + 6'd1;
    if (beat_end) begin
      if (pos == 6'd20) begin
        cur_next.do_retry = 1'b0; cur_next.do_motor = 1'b0;
        last_script = 1'b1;
      end else if (pos == 6'd21 || pos == 6'd22) begin
        cur_next.do_motor = 1'b0;
        last_script = !(cur.do_seek || cur.do_read);
      end else if (pos == 6'd27) begin
        cur_next.do_seek = 1'b0;
        last_script = 1'b1;
      end else begin
        cur_next.do_read = 1'b0;
        last_script = 1'b1;
      end
      step_next = start_of(cur_next);
    end
  end

  // A new command is taken only when the output register is free this cycle.
  assign advance   = busy && (!out_valid || out_ready);
  assign cmd_ready = !busy && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        busy      <= !cmd.do_done;
        cur       <= cmd;
        step      <= start_of(cmd);
        out_valid <= cmd.do_done;
        if (cmd.do_done) begin
          res <= '{action: ACT_DONE, data_byte: 8'd0, wait_ms: 10'd0,
                   status: cmd.status, last: 1'b1};
        end
      end else if (advance) begin
        out_valid <= 1'b1;
        res       <= '{action: beat.action, data_byte: beat.data_byte,
                       wait_ms: beat.wait_ms, status: beat.status,
                       last: beat_end && last_script};
        cur       <= cur_next;
        step      <= step_next;
        busy      <= !(beat_end && last_script);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

[rtl/core/floppy_sector_read_sequencer.sv]
// ============================================================================
// floppy_sector_read_sequencer
// Read-sector sequencer: front end classifies beats, back end emits actions.
// ============================================================================
//   channel   dir   fields
//   in        sink  mode drive lba st0 st1 st2 timed_out
//   out       src   action data_byte wait_ms status last
//   cfg       in    cfg_we cfg_index cfg_wdata
// An input beat is taken into the command register. The back end loads the
// command once it is idle and then emits one action beat per cycle while the
// output is not stalled, up to 21 beats per input; loading a command emits no
// beat, and a lone done beat is loaded directly into the output register.
// The front end takes the next input while the back end is still emitting;
// output stalls hold the back end and, once the command register is full,
// the input. Reset is synchronous and leaves the sequencer idle with unknown
// track cache and motors off.
module floppy_sector_read_sequencer #(
  parameter int SECTORS_PER_TRACK = 18,
  parameter int CYLINDERS = 80
) (
  input  logic       clk,
  input  logic       rst,
  fsrs_if.sink       in,
  fsrs_if.source     out,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_wdata
);
  import fsrs_pkg::*;

  logic [9:0] spinup_wait_ms, seek_settle_ms, recal_settle_ms;
  logic [7:0] gap_length, step_unload_byte, load_dma_byte;
  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;
  req_t       req;
  res_t       res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      spinup_wait_ms   <= 10'd300;
      seek_settle_ms   <= 10'd50;
      recal_settle_ms  <= 10'd500;
      gap_length       <= 8'd27;
      step_unload_byte <= 8'd223;
      load_dma_byte    <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPINUP: spinup_wait_ms   <= cfg_wdata;
        REG_SEEK:   seek_settle_ms   <= cfg_wdata;
        REG_RECAL:  recal_settle_ms  <= cfg_wdata;
        REG_GAP:    gap_length       <= cfg_wdata[7:0];
        REG_STEP:   step_unload_byte <= cfg_wdata[7:0];
        REG_LOAD:   load_dma_byte    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign req = in.payload;

  fsrs_front #(.SPT(SECTORS_PER_TRACK), .CYL(CYLINDERS)) u_front (
    .clk, .rst, .in_valid(in.valid), .in_ready(in.ready), .req,
    .cmd_valid, .cmd_ready, .cmd
  );

  fsrs_back #(.SPT(SECTORS_PER_TRACK)) u_back (
    .clk, .rst, .spinup_wait_ms, .seek_settle_ms, .recal_settle_ms,
    .gap_length, .step_unload_byte, .load_dma_byte,
    .cmd_valid, .cmd_ready, .cmd,
    .out_valid(out.valid), .out_ready(out.ready), .res
  );

  assign out.payload = res;

  // A command is never dropped while it waits.
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid)
    else $error("command lost while waiting");

  // Every done beat closes its item.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out.valid && res.action == ACT_DONE |-> res.last)
    else $error("done beat without last");

  // A stalled output beat stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(res))
    else $error("output beat changed while stalled");
endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Checks the floppy sector read sequencer against a cycle-free predictor.
// Read requests and controller replies are sent as whole read sequences
// with random content, mixed with random noise beats. Each accepted beat
// updates the predictor, which queues the action beats it expects. The
// monitor checks every output beat, field by field, against that queue.
// ============================================================================
module tb_top;
  import fsrs_pkg::*;

  localparam int SPT      = 18;
  localparam int CYLS     = 80;
  localparam int DISK_LBA = CYLS * 2 * SPT;
  localparam int LATENCY  = 40;

  // Command bytes that the sequencer writes to the controller.
  localparam logic [7:0] OP_READ     = 8'h46;
  localparam logic [7:0] OP_SEEK     = 8'h0F;
  localparam logic [7:0] OP_RECAL    = 8'h07;
  localparam logic [7:0] OP_SENSE    = 8'h08;
  localparam logic [7:0] OP_SPECIFY  = 8'h03;
  localparam logic [7:0] DOR_IDLE    = 8'h0C;
  localparam logic [7:0] SIZE_512    = 8'h02;
  localparam logic [7:0] DTL_BYTE    = 8'hFF;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [9:0] cfg_wdata;

  fsrs_if #(.T(req_t)) in_ch ();
  fsrs_if #(.T(res_t)) out_ch ();

  floppy_sector_read_sequencer #(
    .SECTORS_PER_TRACK(SPT),
    .CYLINDERS(CYLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch),
    .out(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state and configuration.
  logic [9:0] spinup_ms, seek_ms, recal_ms;
  logic [7:0] gap_len, step_unload, load_dma;
  phase_t     seq_phase;
  logic [7:0] track_cache [2];
  logic [1:0] motors_on;
  logic       cur_drive;
  logic [7:0] cur_track;
  logic       cur_head;
  logic [5:0] cur_sector;
  logic       retried;

  req_t pending_beats [$];
  res_t expected_actions [$];
  int   errors;
  int   beats_sent;
  bit   quiet;
  int   send_gap;
  int   recv_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // Queue one expected action beat.
  function automatic void emit(logic [2:0] act, logic [7:0] data, logic [9:0] wt,
                               logic [2:0] st);
    res_t r;
    r.action = act;
    r.data_byte = data;
    r.wait_ms = wt;
    r.status = st;
    r.last = 1'b0;
    expected_actions.push_back(r);
  endfunction

  function automatic void finish_seq(logic [2:0] st);
    emit(ACT_DONE, 8'h00, 10'd0, st);
    seq_phase = PH_IDLE;
  endfunction

  function automatic void motor_start();
    emit(ACT_DOR, DOR_IDLE | (8'h10 << cur_drive) | {7'd0, cur_drive}, 10'd0, ST_OK);
    if (!motors_on[cur_drive]) begin
      emit(ACT_WAIT, 8'h00, spinup_ms, ST_OK);
      motors_on[cur_drive] = 1'b1;
    end
  endfunction

  function automatic void seek_cmd();
    emit(ACT_FIFO, OP_SEEK, 10'd0, ST_OK);
    emit(ACT_FIFO, {5'd0, cur_head, 1'b0, cur_drive}, 10'd0, ST_OK);
    emit(ACT_FIFO, cur_track, 10'd0, ST_OK);
    emit(ACT_WAIT, 8'h00, seek_ms, ST_OK);
    emit(ACT_FIFO, OP_SENSE, 10'd0, ST_OK);
    seq_phase = PH_SEEK;
  endfunction

  function automatic void read_cmd();
    emit(ACT_DMA, 8'h00, 10'd0, ST_OK);
    emit(ACT_FIFO, OP_READ, 10'd0, ST_OK);
    emit(ACT_FIFO, {5'd0, cur_head, 1'b0, cur_drive}, 10'd0, ST_OK);
    emit(ACT_FIFO, cur_track, 10'd0, ST_OK);
    emit(ACT_FIFO, {7'd0, cur_head}, 10'd0, ST_OK);
    emit(ACT_FIFO, {2'd0, cur_sector}, 10'd0, ST_OK);
    emit(ACT_FIFO, SIZE_512, 10'd0, ST_OK);
    emit(ACT_FIFO, 8'(SPT), 10'd0, ST_OK);
    emit(ACT_FIFO, gap_len, 10'd0, ST_OK);
    emit(ACT_FIFO, DTL_BYTE, 10'd0, ST_OK);
    seq_phase = PH_READ;
  endfunction

  // Controller reset, specify, motor and recalibrate before the second try.
  function automatic void retry_cmd();
    retried = 1'b1;
    emit(ACT_DOR, 8'h00, 10'd0, ST_OK);
    emit(ACT_WAIT, 8'h00, 10'd5, ST_OK);
    emit(ACT_DOR, DOR_IDLE, 10'd0, ST_OK);
    emit(ACT_WAIT, 8'h00, 10'd20, ST_OK);
    for (int i = 0; i < 4; i++) begin
      emit(ACT_FIFO, OP_SENSE, 10'd0, ST_OK);
      emit(ACT_DISCARD, 8'h00, 10'd0, ST_OK);
    end
    motors_on = 2'b00;
    track_cache[0] = 8'hFF;
    track_cache[1] = 8'hFF;
    emit(ACT_FIFO, OP_SPECIFY, 10'd0, ST_OK);
    emit(ACT_FIFO, step_unload, 10'd0, ST_OK);
    emit(ACT_FIFO, load_dma, 10'd0, ST_OK);
    motor_start();
    emit(ACT_FIFO, OP_RECAL, 10'd0, ST_OK);
    emit(ACT_FIFO, {7'd0, cur_drive}, 10'd0, ST_OK);
    emit(ACT_WAIT, 8'h00, recal_ms, ST_OK);
    emit(ACT_FIFO, OP_SENSE, 10'd0, ST_OK);
    seq_phase = PH_RECAL;
  endfunction

  // Work out the action beats that one accepted input beat causes.
  function automatic void sequence_step(req_t b);
    int n0;
    logic [2:0] rc;
    n0 = expected_actions.size();
    if (b.mode == MODE_REQ && seq_phase == PH_IDLE) begin
      if (b.drive > 2'd1 || int'(b.lba) >= DISK_LBA) begin
        finish_seq(ST_BAD);
      end else begin
        cur_drive = b.drive[0];
        cur_track = 8'(int'(b.lba) / (2 * SPT));
        cur_head = 1'((int'(b.lba) / SPT) & 1);
        cur_sector = 6'((int'(b.lba) % SPT) + 1);
        retried = 1'b0;
        motor_start();
        if (track_cache[cur_drive] == cur_track) read_cmd();
        else seek_cmd();
      end
    end else if (b.mode == MODE_SENSE && seq_phase == PH_SEEK) begin
      track_cache[cur_drive] = cur_track;
      if (b.st0[7:6] == 2'b00 || b.st0[5]) read_cmd();
      else finish_seq(ST_POS);
    end else if (b.mode == MODE_SENSE && seq_phase == PH_RECAL) begin
      track_cache[cur_drive] = 8'h00;
      if (!b.st0[7]) begin
        track_cache[cur_drive] = 8'hFF;
        seek_cmd();
      end else begin
        finish_seq(ST_POS);
      end
    end else if (b.mode == MODE_RES && seq_phase == PH_READ) begin
      if (b.timed_out) rc = ST_TMO;
      else if (b.st0[7]) rc = ST_ABN;
      else if (b.st1[5] || b.st2[5]) rc = ST_CRC;
      else if (b.st1[7]) rc = ST_ABN;
      else rc = ST_OK;
      if ((rc == ST_ABN || rc == ST_CRC) && !retried) retry_cmd();
      else finish_seq(rc);
    end
    if (expected_actions.size() > n0)
      expected_actions[expected_actions.size() - 1].last = 1'b1;
  endfunction

  // Input driver: feeds beats from the pending queue, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) sequence_step(in_ch.payload);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 14);
          in_ch.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_ch.payload <= pending_beats.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random stalls, and each beat checked against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (expected_actions.size() == 0) begin
          $error("unexpected action beat: action %0d data %0h", got.action, got.data_byte);
          errors++;
        end else begin
          want = expected_actions.pop_front();
          if (got.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, got.action);
            errors++;
          end
          if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
            errors++;
          end
          if (got.wait_ms !== want.wait_ms) begin
            $error("wait_ms: expected %0d, got %0d", want.wait_ms, got.wait_ms);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_beat(logic [1:0] mode, logic [1:0] drive, logic [15:0] lba,
                           logic [7:0] st0, logic [7:0] st1, logic [7:0] st2,
                           logic tmo);
    req_t b;
    b.mode = mode;
    b.drive = drive;
    b.lba = lba;
    b.st0 = st0;
    b.st1 = st1;
    b.st2 = st2;
    b.timed_out = tmo;
    pending_beats.push_back(b);
    beats_sent++;
  endtask

  task automatic push_noise();
    push_beat(2'($urandom_range(0, 3)), 2'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Wait until every beat is sent and every expected action has come back.
  task automatic drain();
    @(posedge clk);
    while (pending_beats.size() != 0 || in_ch.valid || expected_actions.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SPINUP: spinup_ms = val;
      REG_SEEK:   seek_ms = val;
      REG_RECAL:  recal_ms = val;
      REG_GAP:    gap_len = val[7:0];
      REG_STEP:   step_unload = val[7:0];
      REG_LOAD:   load_dma = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [9:0] v0, logic [9:0] v1, logic [9:0] v2,
                           logic [9:0] v3, logic [9:0] v4, logic [9:0] v5);
    drain();
    repeat (LATENCY) @(posedge clk);
    write_reg(REG_SPINUP, v0);
    write_reg(REG_SEEK, v1);
    write_reg(REG_RECAL, v2);
    write_reg(REG_GAP, v3);
    write_reg(REG_STEP, v4);
    write_reg(REG_LOAD, v5);
  endtask

  // Answer whatever the sequencer waits for until it is idle again.
  task automatic answer_replies(int bias);
    logic [7:0] s0, s1, s2;
    logic tmo;
    drain();
    while (seq_phase != PH_IDLE) begin
      s0 = 8'($urandom);
      s1 = 8'($urandom);
      s2 = 8'($urandom);
      tmo = 1'($urandom);
      if ($urandom_range(0, 9) < bias) begin
        s0[7] = 1'b0;
        if (seq_phase == PH_READ) begin
          s1[7] = 1'b0;
          s1[5] = 1'b0;
          s2[5] = 1'b0;
          tmo = 1'b0;
        end
      end
      push_beat(seq_phase == PH_READ ? MODE_RES : MODE_SENSE, 2'($urandom), 16'($urandom),
                s0, s1, s2, tmo);
      drain();
    end
  endtask

  task automatic read_sector(logic [1:0] drive, logic [15:0] lba, int bias);
    push_beat(MODE_REQ, drive, lba, 8'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom));
    answer_replies(bias);
  endtask

  // Stimulus: directed cases, then random phases under several settings.
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 3'd0;
    cfg_wdata = 10'd0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    beats_sent = 0;
    quiet = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    spinup_ms = 10'd300;
    seek_ms = 10'd50;
    recal_ms = 10'd500;
    gap_len = 8'd27;
    step_unload = 8'd223;
    load_dma = 8'd2;
    seq_phase = PH_IDLE;
    track_cache[0] = 8'hFF;
    track_cache[1] = 8'hFF;
    motors_on = 2'b00;
    cur_drive = 1'b0;
    cur_track = 8'd0;
    cur_head = 1'b0;
    cur_sector = 6'd0;
    retried = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Bad requests, a mode of 3 and replies while idle.
    push_beat(MODE_REQ, 2'd2, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_REQ, 2'd3, 16'd5, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_beat(MODE_REQ, 2'd0, 16'(DISK_LBA), 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_REQ, 2'd1, 16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(2'd3, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_SENSE, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_RES, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    // Seek, a request while busy, then a good read.
    push_beat(MODE_REQ, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_REQ, 2'd1, 16'd1, 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_SENSE, 2'd0, 16'd0, 8'h20, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_RES, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    // Same track again skips the seek; result times out.
    push_beat(MODE_REQ, 2'd0, 16'd17, 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_RES, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 1'b1);
    // Last sector of the disk on drive one; seek fails.
    push_beat(MODE_REQ, 2'd1, 16'(DISK_LBA - 1), 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_SENSE, 2'd0, 16'd0, 8'hC0, 8'h00, 8'h00, 1'b0);
    // Abnormal result retries; recalibrate fails.
    push_beat(MODE_REQ, 2'd1, 16'(DISK_LBA - 1), 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_SENSE, 2'd0, 16'd0, 8'hE0, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_RES, 2'd0, 16'd0, 8'h80, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_SENSE, 2'd0, 16'd0, 8'h80, 8'h00, 8'h00, 1'b0);
    // CRC result retries, then an abnormal result ends the request.
    push_beat(MODE_REQ, 2'd0, 16'd40, 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_SENSE, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_RES, 2'd0, 16'd0, 8'h00, 8'h00, 8'h20, 1'b0);
    push_beat(MODE_SENSE, 2'd0, 16'd0, 8'h40, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_SENSE, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    push_beat(MODE_RES, 2'd0, 16'd0, 8'h00, 8'h80, 8'h00, 1'b0);
    drain();
    answer_replies(10);

    // Random phases under several register settings, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_all(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        1: write_all(10'h3FF, 10'h3FF, 10'h3FF, 10'h0FF, 10'h0FF, 10'h0FF);
        default: write_all(10'($urandom), 10'($urandom), 10'($urandom),
                           10'($urandom), 10'($urandom), 10'($urandom));
      endcase
      quiet = (ph == 3);
      while (beats_sent < 25 + 36 * (ph + 1)) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 4)) push_noise();
          answer_replies(7);
        end else if ($urandom_range(0, 9) == 0) begin
          read_sector(2'($urandom), 16'($urandom), 7);
        end else begin
          read_sector(2'($urandom_range(0, 1)), 16'($urandom_range(0, DISK_LBA - 1)), 8);
        end
      end
    end

    drain();
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
